@@ rtl/core/hrrs_pkg.sv @@
package hrrs_pkg;

  // table geometry
  localparam int MAX_JOBS = 10;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // field widths
  localparam int NAME_W = 24;
  localparam int MEM_W  = 24;
  localparam int DEV_W  = 4;
  localparam int TIME_W = 16;
  localparam int SUM_W  = TIME_W + 1;
  localparam int PROD_W = SUM_W + TIME_W;

  // command codes
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_LOAD  = 2'd1;
  localparam logic [1:0] FN_SCHED = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEL  = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_FULL = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MEM      = 2'd0;
  localparam logic [1:0] REG_TAPES    = 2'd1;
  localparam logic [1:0] REG_PRINTERS = 2'd2;

  // reset values
  localparam logic [MEM_W-1:0] RST_MEM      = 24'd65536;
  localparam logic [DEV_W-1:0] RST_TAPES    = 4'd4;
  localparam logic [DEV_W-1:0] RST_PRINTERS = 4'd2;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [MEM_W-1:0]  mem;
    logic [DEV_W-1:0]  tapes;
    logic [DEV_W-1:0]  printers;
    logic [SUM_W-1:0]  sum;   // wait + run
    logic [TIME_W-1:0] run;
  } job_t;

  typedef struct packed {
    logic [MEM_W-1:0] mem;
    logic [DEV_W-1:0] tapes;
    logic [DEV_W-1:0] printers;
  } res_t;

  // token that walks the chain, carrying the best candidate so far
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] slot;
    job_t              job;
  } tok_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [SLOT_W-1:0] load_slot;
    logic              deq;
    logic [SLOT_W-1:0] deq_slot;
    job_t              wdata;
  } ctl_t;

endpackage

@@ rtl/core/hrrs_cell.sv @@
module hrrs_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [hrrs_pkg::SLOT_W-1:0] slot_id,
  input  hrrs_pkg::ctl_t             ctl,
  input  hrrs_pkg::res_t             free_res,
  input  hrrs_pkg::tok_t             tok_in,
  output hrrs_pkg::tok_t             tok_out
);

  hrrs_pkg::job_t             job;
  logic                       queued;
  hrrs_pkg::tok_t             tok_next;
  logic [hrrs_pkg::PROD_W-1:0] lhs;
  logic [hrrs_pkg::PROD_W-1:0] rhs;
  logic                       fits;
  logic                       take;

  // store the job on a load aimed at this slot
  always_ff @(posedge clk) begin
    if (ctl.load && ctl.load_slot == slot_id) begin
      job <= ctl.wdata;
    end
  end

  // queue on load, drop on clear or when picked
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      queued <= 1'b0;
    end else if (ctl.load && ctl.load_slot == slot_id) begin
      queued <= 1'b1;
    end else if (ctl.deq && ctl.deq_slot == slot_id) begin
      queued <= 1'b0;
    end
  end

  // compare own ratio against the candidate by cross-multiplying
  always_comb begin
    lhs  = hrrs_pkg::PROD_W'(job.sum) * hrrs_pkg::PROD_W'(tok_in.job.run);
    rhs  = hrrs_pkg::PROD_W'(tok_in.job.sum) * hrrs_pkg::PROD_W'(job.run);
    fits = job.mem <= free_res.mem && job.tapes <= free_res.tapes &&
           job.printers <= free_res.printers;
    take = tok_in.valid && queued && fits && (!tok_in.found || lhs > rhs);
    tok_next = tok_in;
    if (take) begin
      tok_next.found = 1'b1;
      tok_next.slot  = slot_id;
      tok_next.job   = job;
    end
  end

  // hand the token to the older neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/core/highest_response_ratio_scheduler_core.sv @@
// Clear and load give no result; a load into a full table gives one result.
// Schedule: each pick launches a token (ST_START), passes it down the cell chain (ST_SCAN) and
// emits the result (ST_PUT); a run ends with an end result once no queued job fits.
// One command is worked on at a time; the next is taken once the last result has left.
// Reset empties the table, sets resources and registers to 65536 memory, 4 tapes, 2 printers.
module highest_response_ratio_scheduler_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   func,
  input  logic [hrrs_pkg::NAME_W-1:0]  job_name,
  input  logic [hrrs_pkg::MEM_W-1:0]   mem_need,
  input  logic [hrrs_pkg::DEV_W-1:0]   tape_need,
  input  logic [hrrs_pkg::DEV_W-1:0]   printer_need,
  input  logic [hrrs_pkg::TIME_W-1:0]  wait_time,
  input  logic [hrrs_pkg::TIME_W-1:0]  run_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [hrrs_pkg::NAME_W-1:0]  sel_name,
  output logic [hrrs_pkg::SLOT_W-1:0]  sel_slot,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [hrrs_pkg::MEM_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_PUT   = 4'b1000
  } state_t;

  state_t                        state;
  logic [hrrs_pkg::CNT_W-1:0]    used_slots;
  logic [hrrs_pkg::MEM_W-1:0]    total_memory;
  logic [hrrs_pkg::DEV_W-1:0]    total_tapes;
  logic [hrrs_pkg::DEV_W-1:0]    total_printers;
  hrrs_pkg::res_t                free_res;
  hrrs_pkg::tok_t                pick;
  hrrs_pkg::ctl_t                ctl;
  hrrs_pkg::tok_t                tok_link [hrrs_pkg::MAX_JOBS+1];
  logic                          in_accept;
  logic                          out_free;
  logic                          table_full;
  logic [hrrs_pkg::TIME_W-1:0]   run_fixed;

  assign cfg_ready  = 1'b1;
  assign in_ready   = state == ST_IDLE && !out_valid;
  assign in_accept  = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign table_full = used_slots >= hrrs_pkg::CNT_W'(hrrs_pkg::MAX_JOBS);
  assign run_fixed  = (run_time == '0) ? hrrs_pkg::TIME_W'(1) : run_time;

  // broadcast control to the cells
  always_comb begin
    ctl.clear          = in_accept && func == hrrs_pkg::FN_CLEAR;
    ctl.load           = in_accept && func == hrrs_pkg::FN_LOAD && !table_full;
    ctl.load_slot      = hrrs_pkg::SLOT_W'(used_slots);
    ctl.deq            = state == ST_PUT && out_free && pick.found;
    ctl.deq_slot       = pick.slot;
    ctl.wdata.name     = job_name;
    ctl.wdata.mem      = mem_need;
    ctl.wdata.tapes    = tape_need;
    ctl.wdata.printers = printer_need;
    ctl.wdata.run      = run_fixed;
    ctl.wdata.sum      = hrrs_pkg::SUM_W'(wait_time) + hrrs_pkg::SUM_W'(run_fixed);
  end

  // launch an empty token at the newest end of the chain
  always_comb begin
    tok_link[hrrs_pkg::MAX_JOBS]       = '0;
    tok_link[hrrs_pkg::MAX_JOBS].valid = state == ST_START;
  end

  for (genvar i = 0; i < hrrs_pkg::MAX_JOBS; i++) begin : g_cell
    hrrs_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_id  (hrrs_pkg::SLOT_W'(i)),
      .ctl      (ctl),
      .free_res (free_res),
      .tok_in   (tok_link[i+1]),
      .tok_out  (tok_link[i])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_memory   <= hrrs_pkg::RST_MEM;
      total_tapes    <= hrrs_pkg::RST_TAPES;
      total_printers <= hrrs_pkg::RST_PRINTERS;
    end else if (cfg_valid) begin
      case (cfg_index)
        hrrs_pkg::REG_MEM:      total_memory   <= cfg_data;
        hrrs_pkg::REG_TAPES:    total_tapes    <= cfg_data[hrrs_pkg::DEV_W-1:0];
        hrrs_pkg::REG_PRINTERS: total_printers <= cfg_data[hrrs_pkg::DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // table fill and free resources
  always_ff @(posedge clk) begin
    if (rst) begin
      used_slots        <= '0;
      free_res.mem      <= hrrs_pkg::RST_MEM;
      free_res.tapes    <= hrrs_pkg::RST_TAPES;
      free_res.printers <= hrrs_pkg::RST_PRINTERS;
    end else if (ctl.clear) begin
      used_slots        <= '0;
      free_res.mem      <= total_memory;
      free_res.tapes    <= total_tapes;
      free_res.printers <= total_printers;
    end else if (ctl.load) begin
      used_slots <= used_slots + hrrs_pkg::CNT_W'(1);
    end else if (ctl.deq) begin
      free_res.mem      <= free_res.mem - pick.job.mem;
      free_res.tapes    <= free_res.tapes - pick.job.tapes;
      free_res.printers <= free_res.printers - pick.job.printers;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept && func == hrrs_pkg::FN_SCHED) begin
            state <= ST_START;
          end
        end
        ST_START: state <= ST_SCAN;
        ST_SCAN: begin
          if (tok_link[0].valid) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (out_free) begin
            state <= pick.found ? ST_START : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // capture the winner at the oldest end of the chain
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tok_link[0].valid) begin
      pick <= tok_link[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && func == hrrs_pkg::FN_LOAD && table_full) begin
      out_valid <= 1'b1;
      kind      <= hrrs_pkg::KIND_FULL;
      sel_name  <= '0;
      sel_slot  <= '0;
      last      <= 1'b1;
    end else if (state == ST_PUT && out_free) begin
      out_valid <= 1'b1;
      if (pick.found) begin
        kind     <= hrrs_pkg::KIND_SEL;
        sel_name <= pick.job.name;
        sel_slot <= pick.slot;
        last     <= 1'b0;
      end else begin
        kind     <= hrrs_pkg::KIND_END;
        sel_name <= '0;
        sel_slot <= '0;
        last     <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    used_slots <= hrrs_pkg::CNT_W'(hrrs_pkg::MAX_JOBS))
    else $error("table fill count beyond capacity");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_link[0].valid |-> state == ST_SCAN)
    else $error("token left the chain outside a scan");

  a_pick_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && pick.found) |-> hrrs_pkg::CNT_W'(pick.slot) < used_slots)
    else $error("picked slot beyond the filled part of the table");

  a_clear_reload: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> free_res.mem == $past(total_memory) && used_slots == '0)
    else $error("clear did not reload resources");

  a_no_input_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_START) |-> !in_ready)
    else $error("input taken during a schedule run");

endmodule
